[rtl/core/crast_pkg.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer package
// Shared constants and codes for the circle rasterizer front, queue and back.
// ----------------------------------------------------------------------------
package crast_pkg;

  // Default widths of the center coordinates and of the radius.
  localparam int unsigned CoordBitsDefault  = 12;
  localparam int unsigned RadiusBitsDefault = 11;

  // Depth of the job queue between the front and the back.
  localparam int unsigned JobQueueDepth = 2;

  // Operation code of an input item.
  typedef enum logic {
    OpStart = 1'b0,
    OpStep  = 1'b1
  } op_e;

endpackage

[rtl/core/crast_queue.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer job queue
// Small register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module crast_queue import crast_pkg::*; #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = JobQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             wr_en_i,
  input  logic [Width-1:0] wr_data_i,
  output logic             full_o,
  input  logic             rd_en_i,
  output logic [Width-1:0] rd_data_o,
  output logic             empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_wr, do_rd;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign rd_data_o = mem_q[rd_ptr_q];
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (do_wr && !do_rd) begin
      count_d = count_q + CntW'(1);
    end else if (do_rd && !do_wr) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/core/crast_front.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer front
// Accepts items, keeps the circle state and the decision term, and issues
// one job per iteration to the back.
// ----------------------------------------------------------------------------
module crast_front import crast_pkg::*; #(
  parameter int unsigned CoordBits  = CoordBitsDefault,
  parameter int unsigned RadiusBits = RadiusBitsDefault,
  localparam int unsigned StepW     = RadiusBits + 2,
  localparam int unsigned JobW      = 2 * CoordBits + 2 * StepW + 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  accept_i,
  input  logic                  op_i,
  input  logic [CoordBits-1:0]  center_x_i,
  input  logic [CoordBits-1:0]  center_y_i,
  input  logic [RadiusBits-1:0] radius_i,
  input  logic                  filled_i,
  output logic                  job_push_o,
  output logic [JobW-1:0]       job_o
);

  localparam int unsigned DecW = RadiusBits + 5;

  typedef struct packed {
    logic [CoordBits-1:0]    cx;
    logic [CoordBits-1:0]    cy;
    logic signed [StepW-1:0] x;
    logic signed [StepW-1:0] y;
    logic                    fill;
    logic                    done;
  } job_t;

  logic [CoordBits-1:0]    center_col_q;
  logic [CoordBits-1:0]    center_row_q;
  logic [RadiusBits-1:0]   radius_q;
  logic                    fill_mode_q;
  logic signed [StepW-1:0] step_x_q, step_x_d;
  logic signed [StepW-1:0] step_y_q, step_y_d;
  logic signed [DecW-1:0]  dec_q, dec_d;
  logic                    active_q;

  logic signed [DecW-1:0]  xe, ye, re, re_in;
  logic                    is_step;
  job_t                    job;

  assign is_step = accept_i && (op_e'(op_i) == OpStep) && active_q;
  assign xe      = DecW'(step_x_q);
  assign ye      = DecW'(step_y_q);
  assign re      = DecW'(signed'({1'b0, radius_q}));
  assign re_in   = DecW'(signed'({1'b0, radius_i}));

  // One iteration of the selected rule.
  always_comb begin
    dec_d    = dec_q;
    step_x_d = step_x_q + StepW'(1);
    step_y_d = step_y_q;
    if (fill_mode_q) begin
      if (dec_q < 0) begin
        dec_d = dec_q + (xe <<< 2) + DecW'(6);
      end else begin
        dec_d    = dec_q + ((xe - ye) <<< 2) + DecW'(10);
        step_y_d = step_y_q - StepW'(1);
      end
    end else begin
      if (dec_q >= (xe <<< 1)) begin
        dec_d = dec_q - (xe <<< 1) - DecW'(1);
      end else if (dec_q < ((re - ye) <<< 1)) begin
        dec_d    = dec_q + (ye <<< 1) - DecW'(1);
        step_x_d = step_x_q;
        step_y_d = step_y_q - StepW'(1);
      end else begin
        dec_d    = dec_q + ((ye - xe - DecW'(1)) <<< 1);
        step_y_d = step_y_q - StepW'(1);
      end
    end
  end

  always_comb begin
    job.cx   = center_col_q;
    job.cy   = center_row_q;
    job.x    = step_x_q;
    job.y    = step_y_q;
    job.fill = fill_mode_q;
    job.done = (step_y_d < step_x_d);
  end

  assign job_push_o = is_step;
  assign job_o      = job;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_col_q <= '0;
      center_row_q <= '0;
      radius_q     <= '0;
      fill_mode_q  <= 1'b0;
      step_x_q     <= '0;
      step_y_q     <= '0;
      dec_q        <= '0;
      active_q     <= 1'b0;
    end else if (accept_i) begin
      if (op_e'(op_i) == OpStart) begin
        center_col_q <= center_x_i;
        center_row_q <= center_y_i;
        radius_q     <= radius_i;
        fill_mode_q  <= filled_i;
        step_x_q     <= '0;
        step_y_q     <= StepW'(signed'({1'b0, radius_i}));
        dec_q        <= filled_i ? (DecW'(3) - (re_in <<< 1)) : (re_in - DecW'(1));
        active_q     <= 1'b1;
      end else if (active_q) begin
        step_x_q <= step_x_d;
        step_y_q <= step_y_d;
        dec_q    <= dec_d;
        active_q <= !job.done;
      end
    end
  end

endmodule

[rtl/core/crast_back.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer back
// Expands each job into its points or spans, one result per cycle while jobs
// are queued and the receiver keeps up, into an output register.
// ----------------------------------------------------------------------------
module crast_back import crast_pkg::*; #(
  parameter int unsigned CoordBits  = CoordBitsDefault,
  parameter int unsigned RadiusBits = RadiusBitsDefault,
  localparam int unsigned StepW     = RadiusBits + 2,
  localparam int unsigned JobW      = 2 * CoordBits + 2 * StepW + 2,
  localparam int unsigned PixW      = CoordBits + 2,
  localparam int unsigned SpanW     = RadiusBits + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic [JobW-1:0]        job_i,
  input  logic                   job_empty_i,
  output logic                   job_pop_o,
  output logic                   empty_o,
  input  logic                   pop_i,
  output logic signed [PixW-1:0] pixel_x_o,
  output logic signed [PixW-1:0] pixel_y_o,
  output logic [SpanW-1:0]       span_length_o,
  output logic                   last_of_step_o,
  output logic                   circle_done_o
);

  typedef struct packed {
    logic [CoordBits-1:0]    cx;
    logic [CoordBits-1:0]    cy;
    logic signed [StepW-1:0] x;
    logic signed [StepW-1:0] y;
    logic                    fill;
    logic                    done;
  } job_t;

  job_t                   job;
  logic [2:0]             idx_q, idx_d;
  logic                   out_valid_q;
  logic                   load, is_last, swap, neg_x, neg_y;
  logic signed [PixW-1:0] cxe, cye, a, b, px, py;
  logic [SpanW-1:0]       len;

  assign job  = job_t'(job_i);
  assign load = !job_empty_i && (!out_valid_q || pop_i);

  // Outline visits all eight octants; filled mode draws four spans, all
  // starting at or left of center.
  always_comb begin
    if (job.fill) begin
      is_last = (idx_q == 3'd3);
      swap    = idx_q[1];
      neg_x   = 1'b1;
      neg_y   = !idx_q[0];
    end else begin
      is_last = (idx_q == 3'd7);
      swap    = idx_q[0];
      neg_x   = idx_q[1];
      neg_y   = idx_q[2];
    end
  end

  assign cxe = PixW'(signed'({1'b0, job.cx}));
  assign cye = PixW'(signed'({1'b0, job.cy}));
  assign a   = swap ? PixW'(job.y) : PixW'(job.x);
  assign b   = swap ? PixW'(job.x) : PixW'(job.y);
  assign px  = neg_x ? (cxe - a) : (cxe + a);
  assign py  = neg_y ? (cye - b) : (cye + b);
  assign len = job.fill ? ((SpanW'(swap ? job.y : job.x) << 1) + SpanW'(1)) : SpanW'(1);

  assign job_pop_o = load && is_last;
  assign idx_d     = job_pop_o ? 3'd0 : idx_q + 3'd1;
  assign empty_o   = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= idx_d;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      pixel_x_o      <= px;
      pixel_y_o      <= py;
      span_length_o  <= len;
      last_of_step_o <= is_last;
      circle_done_o  <= is_last && job.done;
    end
  end

endmodule

[rtl/core/circle_rasterizer_unit.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer unit
// Rasterizes one circle at a time, one algorithm iteration per step item.
// ----------------------------------------------------------------------------
// A start item (op = 0) loads the center, radius and mode and produces no
// result. Each step item (op = 1) produces one iteration: eight single-pixel
// points in outline mode or four horizontal spans in filled mode, delivered
// in that order one per cycle while the receiver keeps popping. The back
// part has a single output register and sends at most one result transfer
// per cycle. The front part updates the decision term in the cycle it accepts
// a step and queues the iteration in a two-entry job queue, so it keeps
// taking items while the back part is still expanding earlier ones; full
// rises only when that queue is full. A step with no circle in progress is
// accepted and ignored. The last result of a step carries last_of_step, and
// the last result of the circle also carries circle_done. Coordinates are
// not clipped and duplicate points are not merged.
module circle_rasterizer_unit import crast_pkg::*; #(
  parameter int unsigned CoordBits  = CoordBitsDefault,
  parameter int unsigned RadiusBits = RadiusBitsDefault,
  localparam int unsigned PixW      = CoordBits + 2,
  localparam int unsigned SpanW     = RadiusBits + 1
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push,
  output logic                   full,
  input  logic                   op_i,
  input  logic [CoordBits-1:0]   center_x_i,
  input  logic [CoordBits-1:0]   center_y_i,
  input  logic [RadiusBits-1:0]  radius_i,
  input  logic                   filled_i,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [PixW-1:0] pixel_x_o,
  output logic signed [PixW-1:0] pixel_y_o,
  output logic [SpanW-1:0]       span_length_o,
  output logic                   last_of_step_o,
  output logic                   circle_done_o
);

  localparam int unsigned StepW = RadiusBits + 2;
  localparam int unsigned JobW  = 2 * CoordBits + 2 * StepW + 2;

  logic            accept;
  logic            job_push;
  logic [JobW-1:0] job_in;
  logic [JobW-1:0] job_out;
  logic            job_full;
  logic            job_empty;
  logic            job_pop;

  // An input transfer completes whenever the job queue has room.
  assign full   = job_full;
  assign accept = push && !job_full;

  crast_front #(
    .CoordBits (CoordBits),
    .RadiusBits(RadiusBits)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .op_i      (op_i),
    .center_x_i(center_x_i),
    .center_y_i(center_y_i),
    .radius_i  (radius_i),
    .filled_i  (filled_i),
    .job_push_o(job_push),
    .job_o     (job_in)
  );

  crast_queue #(
    .Width(JobW),
    .Depth(JobQueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_en_i  (job_push),
    .wr_data_i(job_in),
    .full_o   (job_full),
    .rd_en_i  (job_pop),
    .rd_data_o(job_out),
    .empty_o  (job_empty)
  );

  crast_back #(
    .CoordBits (CoordBits),
    .RadiusBits(RadiusBits)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .job_i         (job_out),
    .job_empty_i   (job_empty),
    .job_pop_o     (job_pop),
    .empty_o       (empty),
    .pop_i         (pop),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .span_length_o (span_length_o),
    .last_of_step_o(last_of_step_o),
    .circle_done_o (circle_done_o)
  );

endmodule

[bench/circle_span_checker.sv]
// ----------------------------------------------------------------------------
// Circle span checker
// Watches both queue ports of the circle rasterizer, predicts the points and
// spans of each iteration, and compares every result transfer in order.
// ----------------------------------------------------------------------------
module circle_span_checker import crast_pkg::*; (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  input  logic                         full_i,
  input  logic                         op_i,
  input  logic [CoordBitsDefault-1:0]  center_x_i,
  input  logic [CoordBitsDefault-1:0]  center_y_i,
  input  logic [RadiusBitsDefault-1:0] radius_i,
  input  logic                         filled_i,
  input  logic                         empty_i,
  input  logic                         pop_i,
  input  logic [CoordBitsDefault+1:0]  pixel_x_i,
  input  logic [CoordBitsDefault+1:0]  pixel_y_i,
  input  logic [RadiusBitsDefault:0]   span_length_i,
  input  logic                         last_of_step_i,
  input  logic                         circle_done_i,
  output int                           mismatch_count_o,
  output int                           pending_count_o
);

  localparam int unsigned PixW  = CoordBitsDefault + 2;
  localparam int unsigned SpanW = RadiusBitsDefault + 1;

  typedef struct packed {
    logic [PixW-1:0]  pixel_x;
    logic [PixW-1:0]  pixel_y;
    logic [SpanW-1:0] span_length;
    logic             last_of_step;
    logic             circle_done;
  } span_t;

  span_t expected_spans[$];
  int    mismatch_count;

  // Circle state as the block should hold it.
  logic [CoordBitsDefault-1:0]  ctr_col;
  logic [CoordBitsDefault-1:0]  ctr_row;
  logic [RadiusBitsDefault-1:0] rad;
  logic                         fill;
  int                           cur_x;
  int                           cur_y;
  int                           dec;
  logic                         busy;

  assign mismatch_count_o = mismatch_count;

  function automatic span_t make_span(int px, int py, int len);
    span_t s;
    s.pixel_x      = px[PixW-1:0];
    s.pixel_y      = py[PixW-1:0];
    s.span_length  = len[SpanW-1:0];
    s.last_of_step = 1'b0;
    s.circle_done  = 1'b0;
    return s;
  endfunction

  // Loads a circle on a start, or expands one iteration on a step.
  task automatic rasterize_iteration(op_e op, logic [CoordBitsDefault-1:0] cx_in,
                                     logic [CoordBitsDefault-1:0] cy_in,
                                     logic [RadiusBitsDefault-1:0] r_in, logic f_in);
    span_t batch[8];
    int    n;
    int    cx;
    int    cy;
    int    x;
    int    y;
    if (op == OpStart) begin
      ctr_col = cx_in;
      ctr_row = cy_in;
      rad     = r_in;
      fill    = f_in;
      cur_x   = 0;
      cur_y   = int'(r_in);
      dec     = f_in ? 3 - 2 * int'(r_in) : int'(r_in) - 1;
      busy    = 1'b1;
      return;
    end
    if (!busy) return;
    cx = int'(ctr_col);
    cy = int'(ctr_row);
    x  = cur_x;
    y  = cur_y;
    if (fill) begin
      batch[0] = make_span(cx - x, cy - y, 2 * x + 1);
      batch[1] = make_span(cx - x, cy + y, 2 * x + 1);
      batch[2] = make_span(cx - y, cy - x, 2 * y + 1);
      batch[3] = make_span(cx - y, cy + x, 2 * y + 1);
      n = 4;
      if (dec < 0) begin
        dec = dec + 4 * cur_x + 6;
      end else begin
        dec = dec + 4 * (cur_x - cur_y) + 10;
        cur_y--;
      end
      cur_x++;
    end else begin
      batch[0] = make_span(cx + x, cy + y, 1);
      batch[1] = make_span(cx + y, cy + x, 1);
      batch[2] = make_span(cx - x, cy + y, 1);
      batch[3] = make_span(cx - y, cy + x, 1);
      batch[4] = make_span(cx + x, cy - y, 1);
      batch[5] = make_span(cx + y, cy - x, 1);
      batch[6] = make_span(cx - x, cy - y, 1);
      batch[7] = make_span(cx - y, cy - x, 1);
      n = 8;
      if (dec >= 2 * cur_x) begin
        dec = dec - 2 * cur_x - 1;
        cur_x++;
      end else if (dec < 2 * (int'(rad) - cur_y)) begin
        dec = dec + 2 * cur_y - 1;
        cur_y--;
      end else begin
        dec = dec + 2 * (cur_y - cur_x - 1);
        cur_y--;
        cur_x++;
      end
    end
    batch[n-1].last_of_step = 1'b1;
    if (cur_y < cur_x) begin
      busy = 1'b0;
      batch[n-1].circle_done = 1'b1;
    end
    for (int i = 0; i < n; i++) expected_spans.push_back(batch[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    span_t exp_span;
    span_t got_span;
    if (!rst_ni) begin
      expected_spans.delete();
      mismatch_count  = 0;
      ctr_col         = '0;
      ctr_row         = '0;
      rad             = '0;
      fill            = 1'b0;
      cur_x           = 0;
      cur_y           = 0;
      dec             = 0;
      busy            = 1'b0;
      pending_count_o <= 0;
    end else begin
      // Results first; a transfer in at this edge cannot show up until later.
      if (pop_i && !empty_i) begin
        got_span = '{pixel_x_i, pixel_y_i, span_length_i, last_of_step_i, circle_done_i};
        if (expected_spans.size() == 0) begin
          if (mismatch_count < 10) $display("unexpected result: x=%0d y=%0d len=%0d",
                                            $signed(pixel_x_i), $signed(pixel_y_i),
                                            span_length_i);
          mismatch_count++;
        end else begin
          exp_span = expected_spans.pop_front();
          if (got_span != exp_span) begin
            if (mismatch_count < 10) begin
              $display("span check failed: expected x=%0d y=%0d len=%0d last=%0b done=%0b",
                       $signed(exp_span.pixel_x), $signed(exp_span.pixel_y),
                       exp_span.span_length, exp_span.last_of_step, exp_span.circle_done);
              $display("                   got      x=%0d y=%0d len=%0d last=%0b done=%0b",
                       $signed(got_span.pixel_x), $signed(got_span.pixel_y),
                       got_span.span_length, got_span.last_of_step, got_span.circle_done);
            end
            mismatch_count++;
          end
        end
      end
      if (push_i && !full_i) begin
        rasterize_iteration(op_e'(op_i), center_x_i, center_y_i, radius_i, filled_i);
      end
      pending_count_o <= expected_spans.size();
    end
  end

endmodule

[bench/circle_rasterizer_unit_tb.sv]
// ----------------------------------------------------------------------------
// Circle rasterizer unit testbench
// Drives start and step items into the rasterizer under several idling
// patterns and lets the span checker compare every result transfer.
// ----------------------------------------------------------------------------
module circle_rasterizer_unit_tb;
  import crast_pkg::*;

  // Cycles without any transfer before the run is declared hung. Even with
  // heavy random stalls on both sides, a correct block keeps moving, so this
  // leaves a wide margin.
  localparam int IdleLimit     = 2000;
  // The block holds at most two queued iterations of eight results each plus
  // one result in its output register; this wait covers anything still inside.
  localparam int DrainCycles   = 40;
  localparam int ItemsPerPhase = 75;

  logic                          clk;
  logic                          rst_n       = 1'b0;
  logic                          push        = 1'b0;
  logic                          pop         = 1'b0;
  logic                          op_i        = 1'b0;
  logic [CoordBitsDefault-1:0]   center_x    = '0;
  logic [CoordBitsDefault-1:0]   center_y    = '0;
  logic [RadiusBitsDefault-1:0]  radius      = '0;
  logic                          filled      = 1'b0;
  logic                          full;
  logic                          empty;
  logic signed [CoordBitsDefault+1:0] pixel_x;
  logic signed [CoordBitsDefault+1:0] pixel_y;
  logic [RadiusBitsDefault:0]    span_length;
  logic                          last_of_step;
  logic                          circle_done;

  int mismatches;
  int pending;
  int idle_pct  = 0;
  int stall_pct = 0;
  int quiet_cycles = 0;

  // Phase table: sender idle and receiver stall, in percent of cycles.
  int idle_tbl[4]  = '{0, 61, 0, 34};
  int stall_tbl[4] = '{0, 0, 61, 34};

  circle_rasterizer_unit u_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .op_i           (op_i),
    .center_x_i     (center_x),
    .center_y_i     (center_y),
    .radius_i       (radius),
    .filled_i       (filled),
    .empty          (empty),
    .pop            (pop),
    .pixel_x_o      (pixel_x),
    .pixel_y_o      (pixel_y),
    .span_length_o  (span_length),
    .last_of_step_o (last_of_step),
    .circle_done_o  (circle_done)
  );

  circle_span_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .push_i           (push),
    .full_i           (full),
    .op_i             (op_i),
    .center_x_i       (center_x),
    .center_y_i       (center_y),
    .radius_i         (radius),
    .filled_i         (filled),
    .empty_i          (empty),
    .pop_i            (pop),
    .pixel_x_i        (pixel_x),
    .pixel_y_i        (pixel_y),
    .span_length_i    (span_length),
    .last_of_step_i   (last_of_step),
    .circle_done_i    (circle_done),
    .mismatch_count_o (mismatches),
    .pending_count_o  (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // The receiver decides each cycle whether to take a result. With the stall
  // rate at zero, pop stays high and results drain at full speed.
  always @(posedge clk) begin
    pop <= ($urandom_range(0, 99) >= stall_pct);
  end

  // Hang detection: any transfer on either side restarts the count.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == IdleLimit) begin
      $display("circle_rasterizer_unit: mismatch");
      $finish;
    end
  end

  // Presents one item, with random idle cycles in front of it according to
  // the current phase, and returns at the edge where the transfer happens.
  // Push is never dropped between back-to-back items.
  task automatic send_item(op_e op, logic [CoordBitsDefault-1:0] cx,
                           logic [CoordBitsDefault-1:0] cy,
                           logic [RadiusBitsDefault-1:0] r, logic f);
    while ($urandom_range(0, 99) < idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push     <= 1'b1;
    op_i     <= op;
    center_x <= cx;
    center_y <= cy;
    radius   <= r;
    filled   <= f;
    do @(posedge clk); while (full);
  endtask

  // Step items carry random payload; the block must ignore it.
  task automatic send_step();
    send_item(OpStep, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
              11'($urandom_range(0, 2047)), 1'($urandom_range(0, 1)));
  endtask

  // Holds the sender back until the checker has nothing left to wait for.
  task automatic drain_results();
    push <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int counted;
    int rad;
    int nsteps;
    int extra;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. A step before any circle has been started is ignored.
    send_step();
    // Zero radius outline: one step yields the center points and ends the
    // circle; the following step finds nothing in progress.
    send_item(OpStart, 12'd2048, 12'd2048, 11'd0, 1'b0);
    send_step();
    send_step();
    // Zero radius filled circle at the far corner of the coordinate range.
    send_item(OpStart, 12'd4095, 12'd4095, 11'd0, 1'b1);
    send_step();
    // Largest radius at the origin: negative, unclipped coordinates, and the
    // widest spans. The circle is abandoned by the next start.
    send_item(OpStart, 12'd0, 12'd0, 11'd2047, 1'b1);
    send_step();
    send_step();
    send_item(OpStart, 12'd4095, 12'd0, 11'd2047, 1'b0);
    send_step();
    send_step();
    // Radius one outline run to completion, with duplicate points.
    send_item(OpStart, 12'd0, 12'd4095, 11'd1, 1'b0);
    send_step();
    send_step();
    send_step();
    // Small filled circle run past its end.
    send_item(OpStart, 12'd1000, 12'd3000, 11'd3, 1'b1);
    repeat (4) send_step();
    // The sender waits here until every result so far has been taken.
    drain_results();

    // Random part, one block of items per idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct  = idle_tbl[ph];
      stall_pct = stall_tbl[ph];
      counted   = 0;
      while (counted < ItemsPerPhase) begin
        if ($urandom_range(0, 99) < 15) begin
          // Noise: arbitrary items, including starts and stray steps.
          repeat ($urandom_range(1, 3)) begin
            send_item(op_e'(1'($urandom_range(0, 1))), 12'($urandom_range(0, 4095)),
                      12'($urandom_range(0, 4095)), 11'($urandom_range(0, 2047)),
                      1'($urandom_range(0, 1)));
            counted++;
          end
        end else begin
          // Well-formed circle. Most are small and run to completion, some
          // steps past the end; a few large ones are cut short by the next
          // start.
          if ($urandom_range(0, 99) < 8) begin
            rad    = $urandom_range(16, 2047);
            nsteps = $urandom_range(2, 8);
            extra  = 0;
          end else begin
            rad    = $urandom_range(0, 12);
            nsteps = (rad * 3) / 4 + 1;
            extra  = $urandom_range(0, 2);
          end
          send_item(OpStart, 12'($urandom_range(0, 4095)), 12'($urandom_range(0, 4095)),
                    11'(rad), 1'($urandom_range(0, 1)));
          counted++;
          repeat (nsteps) begin
            send_step();
            counted++;
          end
          repeat (extra) begin
            send_step();
            counted++;
          end
        end
      end
      if (ph == 1) drain_results();
    end

    // Wind down: let every expected result arrive, then give the block time
    // to show anything it should not have produced.
    drain_results();
    repeat (DrainCycles) @(posedge clk);
    if (mismatches == 0 && pending == 0) begin
      $display("circle_rasterizer_unit: match");
    end else begin
      $display("circle_rasterizer_unit: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/core/crast_pkg.sv
rtl/core/crast_queue.sv
rtl/core/crast_front.sv
rtl/core/crast_back.sv
rtl/core/circle_rasterizer_unit.sv
bench/circle_span_checker.sv
bench/circle_rasterizer_unit_tb.sv
